// ===== sv/bsfd_pkg.sv =====
// Shared types, constants and functions for the byte-stuffed frame decoder.
package bsfd_pkg;

  localparam int unsigned FRAME_OVERHEAD = 7;
  localparam int unsigned HEADER_BYTES   = 4;
  localparam int unsigned CRC_BYTES      = 2;
  localparam int unsigned CNT_W          = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;

  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [7:0]  RST_END_FLAG    = 8'd126;
  localparam logic [7:0]  RST_ESCAPE      = 8'd125;
  localparam logic [7:0]  RST_XOR_MASK    = 8'd32;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd4096;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_OVER_MAX     = 3'd2,
    ST_OVER_FRAME   = 3'd3,
    ST_CRC_INCOMPL  = 3'd4,
    ST_CRC_MISMATCH = 3'd5
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_END_FLAG    = 2'd0,
    CFG_ESCAPE      = 2'd1,
    CFG_XOR_MASK    = 2'd2,
    CFG_MAX_PAYLOAD = 2'd3
  } cfg_idx_t;

  // One received byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       restart;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  source_address;
    logic [7:0]  remote_address;
    logic [15:0] frame_length;
    status_t     status;
    logic        last;
  } result_t;

  // CRC-16/ARC update for one byte, reflected form.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

endpackage

// ===== sv/bsfd_in_stage.sv =====
// Input register that holds one received byte until the decoder takes it.
module bsfd_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  logic                  advance,
  output bsfd_pkg::item_t       item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       restart_r;

  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r    <= in_tdata;
      restart_r <= in_tuser;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;
  assign item.restart = restart_r;

endmodule

// ===== sv/bsfd_core.sv =====
// Frame state, configuration registers and the per-byte decode logic.
module bsfd_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bsfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  bsfd_pkg::item_t                   item,
  input  logic                              step,
  output logic                              res_valid,
  output bsfd_pkg::result_t                 res
);

  logic [7:0]  end_flag_r;
  logic [7:0]  escape_r;
  logic [7:0]  xor_mask_r;
  logic [15:0] max_payload_r;

  logic                       hunting_r, hunting_nxt;
  logic                       esc_pend_r, esc_pend_nxt;
  logic [bsfd_pkg::CNT_W-1:0] raw_cnt_r, raw_cnt_nxt;
  logic [bsfd_pkg::CNT_W-1:0] dec_cnt_r, dec_cnt_nxt;
  logic [7:0]                 source_r, source_nxt;
  logic [7:0]                 remote_r, remote_nxt;
  logic [15:0]                length_r, length_nxt;
  logic [15:0]                run_crc_r, run_crc_nxt;
  logic [15:0]                rx_crc_r, rx_crc_nxt;

  logic [bsfd_pkg::CNT_W-1:0] raw_inc;
  logic [bsfd_pkg::CNT_W-1:0] raw_room;
  logic [bsfd_pkg::CNT_W:0]   need_cnt;
  logic [bsfd_pkg::CNT_W-1:0] pay_idx;
  logic [bsfd_pkg::CNT_W-1:0] len_ext;
  bsfd_pkg::status_t          close_st;
  logic                       dec_take;
  logic [7:0]                 dec_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_flag_r    <= bsfd_pkg::RST_END_FLAG;
      escape_r      <= bsfd_pkg::RST_ESCAPE;
      xor_mask_r    <= bsfd_pkg::RST_XOR_MASK;
      max_payload_r <= bsfd_pkg::RST_MAX_PAYLOAD;
    end else if (cfg_we) begin
      unique case (bsfd_pkg::cfg_idx_t'(cfg_addr))
        bsfd_pkg::CFG_END_FLAG:    end_flag_r    <= cfg_wdata[7:0];
        bsfd_pkg::CFG_ESCAPE:      escape_r      <= cfg_wdata[7:0];
        bsfd_pkg::CFG_XOR_MASK:    xor_mask_r    <= cfg_wdata[7:0];
        bsfd_pkg::CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata;
        default:                   ;
      endcase
    end
  end

  // Frame checks, taken in priority order at the closing flag.
  assign raw_inc  = bsfd_pkg::sat_inc(raw_cnt_r);
  assign raw_room = raw_inc - bsfd_pkg::CNT_W'(bsfd_pkg::FRAME_OVERHEAD);
  assign len_ext  = {1'b0, length_r};
  assign need_cnt = (bsfd_pkg::CNT_W + 1)'(bsfd_pkg::HEADER_BYTES + bsfd_pkg::CRC_BYTES)
                    + {2'b00, length_r};
  assign pay_idx  = dec_cnt_r - bsfd_pkg::CNT_W'(bsfd_pkg::HEADER_BYTES);

  always_comb begin
    if (raw_inc < bsfd_pkg::CNT_W'(bsfd_pkg::FRAME_OVERHEAD) ||
        dec_cnt_r < bsfd_pkg::CNT_W'(bsfd_pkg::HEADER_BYTES)) begin
      close_st = bsfd_pkg::ST_TOO_SHORT;
    end else if (length_r > max_payload_r) begin
      close_st = bsfd_pkg::ST_OVER_MAX;
    end else if (len_ext > raw_room) begin
      close_st = bsfd_pkg::ST_OVER_FRAME;
    end else if ({1'b0, dec_cnt_r} < need_cnt) begin
      close_st = bsfd_pkg::ST_CRC_INCOMPL;
    end else if (rx_crc_r != run_crc_r) begin
      close_st = bsfd_pkg::ST_CRC_MISMATCH;
    end else begin
      close_st = bsfd_pkg::ST_OK;
    end
  end

  always_comb begin
    hunting_nxt  = hunting_r;
    esc_pend_nxt = esc_pend_r;
    raw_cnt_nxt  = raw_cnt_r;
    dec_cnt_nxt  = dec_cnt_r;
    source_nxt   = source_r;
    remote_nxt   = remote_r;
    length_nxt   = length_r;
    run_crc_nxt  = run_crc_r;
    rx_crc_nxt   = rx_crc_r;
    res_valid    = 1'b0;
    res          = '0;
    dec_take     = 1'b0;
    dec_byte     = item.rx_byte;

    if (item.valid) begin
      if (item.restart || hunting_r) begin
        // Hunting: only a flag matters, and it opens a fresh frame.
        if (item.rx_byte == end_flag_r) begin
          hunting_nxt = 1'b0;
        end else begin
          hunting_nxt = 1'b1;
        end
        esc_pend_nxt = 1'b0;
        raw_cnt_nxt  = '0;
        dec_cnt_nxt  = '0;
        source_nxt   = '0;
        remote_nxt   = '0;
        length_nxt   = '0;
        run_crc_nxt  = '0;
        rx_crc_nxt   = '0;
      end else begin
        raw_cnt_nxt = raw_inc;
        if (item.rx_byte == end_flag_r) begin
          // A flag always closes the frame, even right after an escape.
          res_valid          = 1'b1;
          res.kind           = bsfd_pkg::KIND_STATUS;
          res.source_address = source_r;
          res.remote_address = remote_r;
          res.frame_length   = length_r;
          res.status         = close_st;
          res.last           = 1'b1;
          esc_pend_nxt = 1'b0;
          raw_cnt_nxt  = '0;
          dec_cnt_nxt  = '0;
          source_nxt   = '0;
          remote_nxt   = '0;
          length_nxt   = '0;
          run_crc_nxt  = '0;
          rx_crc_nxt   = '0;
        end else if (esc_pend_r) begin
          esc_pend_nxt = 1'b0;
          dec_take     = 1'b1;
          dec_byte     = item.rx_byte ^ xor_mask_r;
        end else if (item.rx_byte == escape_r) begin
          esc_pend_nxt = 1'b1;
        end else begin
          dec_take = 1'b1;
        end
      end

      if (dec_take) begin
        dec_cnt_nxt = bsfd_pkg::sat_inc(dec_cnt_r);
        priority if (dec_cnt_r == bsfd_pkg::CNT_W'(0)) begin
          source_nxt = dec_byte;
        end else if (dec_cnt_r == bsfd_pkg::CNT_W'(1)) begin
          remote_nxt = dec_byte;
        end else if (dec_cnt_r == bsfd_pkg::CNT_W'(2)) begin
          length_nxt = {length_r[15:8], dec_byte};
        end else if (dec_cnt_r == bsfd_pkg::CNT_W'(3)) begin
          length_nxt = {dec_byte, length_r[7:0]};
        end else if (pay_idx < len_ext) begin
          run_crc_nxt = bsfd_pkg::crc16_byte(run_crc_r, dec_byte);
          // An oversized frame is still checked but its payload is withheld.
          if (length_r <= max_payload_r) begin
            res_valid        = 1'b1;
            res.kind         = bsfd_pkg::KIND_PAYLOAD;
            res.payload_byte = dec_byte;
          end
        end else if (pay_idx == len_ext) begin
          rx_crc_nxt = {dec_byte, rx_crc_r[7:0]};
        end else if (pay_idx == len_ext + 1'b1) begin
          rx_crc_nxt = {rx_crc_r[15:8], dec_byte};
        end else begin
          // Bytes after the CRC only count.
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r  <= 1'b1;
      esc_pend_r <= 1'b0;
      raw_cnt_r  <= '0;
      dec_cnt_r  <= '0;
      source_r   <= '0;
      remote_r   <= '0;
      length_r   <= '0;
      run_crc_r  <= '0;
      rx_crc_r   <= '0;
    end else if (step) begin
      hunting_r  <= hunting_nxt;
      esc_pend_r <= esc_pend_nxt;
      raw_cnt_r  <= raw_cnt_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      source_r   <= source_nxt;
      remote_r   <= remote_nxt;
      length_r   <= length_nxt;
      run_crc_r  <= run_crc_nxt;
      rx_crc_r   <= rx_crc_nxt;
    end
  end

endmodule

// ===== sv/bsfd_out_stage.sv =====
// Result register that holds one result item until the sink takes it.
module bsfd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  bsfd_pkg::result_t    res,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output bsfd_pkg::result_t    out_res
);

  logic              valid_r;
  bsfd_pkg::result_t data_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = data_r;

endmodule

// ===== sv/byte_stuffed_frame_decoder_crc16.sv =====
// Top level of the byte-stuffed frame decoder with CRC-16/ARC check.
//
//   Channel | Direction | Handshake            | Contents
//   --------+-----------+----------------------+------------------------------------------
//   in_     | sink      | in_tvalid/in_tready  | one raw byte, restart flag in tuser
//   out_    | source    | out_tvalid/out_tready| payload byte or end-of-frame status item
//   cfg_    | sink      | cfg_we               | flag, escape, escape mask, max payload
//
// Each item passes through an input register, combinational decode logic and a
// result register, so the block takes one item per cycle when the sink keeps
// out_tready high. The longest path is the eight-step CRC byte update and the
// frame-length compares that feed the result register.
// An accepted item is held in the input register; its result shows on out_tvalid
// once the result register loads it, and stays there until the sink takes it.
// Reset is synchronous and active low; it empties both registers, sets the
// configuration to its defaults and starts the decoder hunting for a flag.
// When the result register is full and not taken, the input register holds
// its item and in_tready drops; items that produce no result still move on.
module byte_stuffed_frame_decoder_crc16 (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item: in_tdata[7:0] rx_byte.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bsfd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser[0] restart.
  input  logic                                in_tuser,
  // Result item: out_tdata[7:0] payload_byte, [15:8] source_address,
  // [23:16] remote_address, [39:24] frame_length, [42:40] status,
  // [47:43] zero fill.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bsfd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser[0] kind: 0 payload byte, 1 end-of-frame status.
  output logic                                out_tuser,
  output logic                                out_tlast,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [bsfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bsfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bsfd_pkg::item_t   item;
  bsfd_pkg::result_t res;
  bsfd_pkg::result_t out_res;
  logic              res_valid;
  logic              out_free;
  logic              advance;

  // The held item moves on when it makes no result or the result slot is free.
  assign advance = item.valid && (!res_valid || out_free);

  bsfd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .item      (item)
  );

  bsfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .step      (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  bsfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {5'b00000, out_res.status, out_res.frame_length,
                      out_res.remote_address, out_res.source_address,
                      out_res.payload_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// ===== sv/bsfd_checker.sv =====
// Port-level assertions for the frame decoder, bound to the top level.
module bsfd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bsfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // The output register is empty in the first cycle after reset is released.
  a_reset_empty: assert property (@(posedge clk) rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The status item is the one that ends a frame.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (out_tuser == bsfd_pkg::KIND_STATUS))
    else $error("tlast disagrees with kind");

  // Payload items carry nothing but the byte.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bsfd_pkg::KIND_PAYLOAD |-> out_tdata[47:8] == '0)
    else $error("payload item has header fields set");

  // Status items carry a defined code and no payload byte.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bsfd_pkg::KIND_STATUS |->
      out_tdata[7:0] == '0 && out_tdata[47:43] == '0 &&
      out_tdata[42:40] <= bsfd_pkg::ST_CRC_MISMATCH)
    else $error("status item malformed");

endmodule

bind byte_stuffed_frame_decoder_crc16 bsfd_checker u_bsfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/byte_stuffed_frame_decoder_crc16_tb.sv =====
// Self-checking testbench for the byte-stuffed frame decoder with CRC-16/ARC check.
`timescale 1ns / 1ps

import bsfd_pkg::*;

// Tracks the deframer state, turns every accepted byte into the result items
// it should cause, and compares the items that come out against them.
class frame_scoreboard;
  bit [7:0]  flag_val;
  bit [7:0]  esc_val;
  bit [7:0]  xor_mask;
  bit [15:0] max_len;

  bit        hunting_now;
  bit        esc_pend;
  bit [16:0] raw_n;
  bit [16:0] dec_n;
  bit [7:0]  src_byte;
  bit [7:0]  rem_byte;
  bit [15:0] len_field;
  bit [15:0] crc_acc;
  bit [15:0] crc_rx;

  result_t   expected_q[$];
  int        errors;
  int        n_payload;
  int        n_status;

  function new();
    flag_val    = RST_END_FLAG;
    esc_val     = RST_ESCAPE;
    xor_mask    = RST_XOR_MASK;
    max_len     = RST_MAX_PAYLOAD;
    hunting_now = 1'b1;
    open_frame();
    errors      = 0;
    n_payload   = 0;
    n_status    = 0;
  endfunction

  function void open_frame();
    esc_pend  = 1'b0;
    raw_n     = '0;
    dec_n     = '0;
    src_byte  = '0;
    rem_byte  = '0;
    len_field = '0;
    crc_acc   = '0;
    crc_rx    = '0;
  endfunction

  function void write_reg(cfg_idx_t idx, bit [15:0] v);
    case (idx)
      CFG_END_FLAG:    flag_val = v[7:0];
      CFG_ESCAPE:      esc_val  = v[7:0];
      CFG_XOR_MASK:    xor_mask = v[7:0];
      CFG_MAX_PAYLOAD: max_len  = v;
      default: ;
    endcase
  endfunction

  // Reflected CRC-16 shifted one data bit at a time, LSB first.
  function bit [15:0] crc_arc(bit [15:0] c, bit [7:0] d);
    bit fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY_REFL;
      end
    end
    return c;
  endfunction

  function bit [16:0] bump(bit [16:0] v);
    return (v == '1) ? v : v + 17'd1;
  endfunction

  function status_t close_code();
    if (raw_n < FRAME_OVERHEAD || dec_n < HEADER_BYTES) return ST_TOO_SHORT;
    if (len_field > max_len) return ST_OVER_MAX;
    if (int'(len_field) > int'(raw_n) - int'(FRAME_OVERHEAD)) return ST_OVER_FRAME;
    if (int'(dec_n) < int'(HEADER_BYTES) + int'(len_field) + int'(CRC_BYTES)) begin
      return ST_CRC_INCOMPL;
    end
    if (crc_rx != crc_acc) return ST_CRC_MISMATCH;
    return ST_OK;
  endfunction

  function void take_byte(bit [7:0] b);
    int      p;
    result_t r;
    case (dec_n)
      17'd0: src_byte = b;
      17'd1: rem_byte = b;
      17'd2: len_field[7:0] = b;
      17'd3: len_field[15:8] = b;
      default: begin
        p = int'(dec_n) - int'(HEADER_BYTES);
        if (p < int'(len_field)) begin
          crc_acc = crc_arc(crc_acc, b);
          if (len_field <= max_len) begin
            r              = '0;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.status       = ST_OK;
            expected_q.push_back(r);
          end
        end else if (p == int'(len_field)) begin
          crc_rx[15:8] = b;
        end else if (p == int'(len_field) + 1) begin
          crc_rx[7:0] = b;
        end
      end
    endcase
    dec_n = bump(dec_n);
  endfunction

  function void note_input(bit [7:0] b, bit rs);
    result_t r;
    if (rs) begin
      hunting_now = 1'b1;
      open_frame();
    end
    if (hunting_now) begin
      if (b == flag_val) begin
        hunting_now = 1'b0;
        open_frame();
      end
      return;
    end
    raw_n = bump(raw_n);
    if (b == flag_val) begin
      r.kind           = KIND_STATUS;
      r.payload_byte   = '0;
      r.source_address = src_byte;
      r.remote_address = rem_byte;
      r.frame_length   = len_field;
      r.status         = close_code();
      r.last           = 1'b1;
      expected_q.push_back(r);
      open_frame();
      return;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      take_byte(b ^ xor_mask);
      return;
    end
    if (b == esc_val) begin
      esc_pend = 1'b1;
      return;
    end
    take_byte(b);
  endfunction

  function void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= 100) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      end
    end
  endfunction

  function void check_result(result_t act, bit [4:0] fill);
    result_t e;
    if (expected_q.size() == 0) begin
      errors++;
      $error("result item with nothing expected: kind %0d, payload %0d, status %0d",
             act.kind, act.payload_byte, act.status);
      return;
    end
    e = expected_q.pop_front();
    if (e.kind == KIND_PAYLOAD) n_payload++;
    else n_status++;
    check_field("kind", 32'(e.kind), 32'(act.kind));
    check_field("payload_byte", 32'(e.payload_byte), 32'(act.payload_byte));
    check_field("source_address", 32'(e.source_address), 32'(act.source_address));
    check_field("remote_address", 32'(e.remote_address), 32'(act.remote_address));
    check_field("frame_length", 32'(e.frame_length), 32'(act.frame_length));
    check_field("status", 32'(e.status), 32'(act.status));
    check_field("last", 32'(e.last), 32'(act.last));
    check_field("tdata zero fill", 32'd0, 32'(fill));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module byte_stuffed_frame_decoder_crc16_tb;

  // Roughly 1600 items, each delayed at worst by a random sender gap plus a
  // random sink stall per result, stay well under the limit.
  localparam int unsigned RUN_LIMIT   = 500000;
  // Random items per register setting; six settings give about 1600 items.
  localparam int unsigned PHASE_ITEMS = 270;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  frame_scoreboard sb = new();

  // When set, both the sender and the sink run without idle cycles.
  bit          steady;
  int unsigned item_count;
  int unsigned cycle_count;
  // Decoded bytes of the frame about to be sent, and its payload part.
  bit [7:0]    frame_q[$];
  bit [7:0]    pay_q[$];

  byte_stuffed_frame_decoder_crc16 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // A hung handshake ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("byte_stuffed_frame_decoder_crc16_tb: FAIL");
      $finish;
    end
  end

  // Every result item taken at a rising edge is unpacked from tdata, tuser and
  // tlast and handed to the scoreboard.
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind           = out_tuser;
      got.payload_byte   = out_tdata[7:0];
      got.source_address = out_tdata[15:8];
      got.remote_address = out_tdata[23:16];
      got.frame_length   = out_tdata[39:24];
      got.status         = status_t'(out_tdata[42:40]);
      got.last           = out_tlast;
      sb.check_result(got, out_tdata[47:43]);
    end
  end

  // The sink draws a stall before every result item, then holds tready high
  // until the item is taken. In steady stretches it never stalls.
  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      repeat (stall) @(negedge clk) out_tready <= 1'b0;
      @(negedge clk) out_tready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_tvalid)) @(posedge clk);
    end
  end

  // Offers one raw byte after a random gap and returns once it is accepted.
  // When gap is zero, tvalid simply stays high into the next item.
  task automatic send_raw(bit [7:0] b, bit rs);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b, rs);
    item_count++;
  endtask

  // In noisy mode a byte now and then carries a restart, which drops the frame.
  task automatic send_byte(bit [7:0] b, bit noisy);
    send_raw(b, noisy && ($urandom_range(0, 63) == 0));
  endtask

  // Sends the decoded bytes with byte stuffing. A byte equal to the flag or
  // the escape value goes out as an escape followed by the masked byte.
  task automatic send_stuffed(bit noisy);
    foreach (frame_q[i]) begin
      if (frame_q[i] == sb.flag_val || frame_q[i] == sb.esc_val) begin
        send_byte(sb.esc_val, noisy);
        send_byte(frame_q[i] ^ sb.xor_mask, noisy);
      end else begin
        send_byte(frame_q[i], noisy);
      end
    end
  endtask

  // Assembles header, payload and the big-endian CRC of the payload.
  task automatic build_frame(bit [7:0] src, bit [7:0] rem, bit [15:0] lenf);
    bit [15:0] crc;
    crc = '0;
    frame_q.delete();
    frame_q.push_back(src);
    frame_q.push_back(rem);
    frame_q.push_back(lenf[7:0]);
    frame_q.push_back(lenf[15:8]);
    foreach (pay_q[i]) begin
      crc = sb.crc_arc(crc, pay_q[i]);
      frame_q.push_back(pay_q[i]);
    end
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
  endtask

  // A quarter of the payload bytes hit the flag or escape value so that
  // stuffing is exercised all the time.
  task automatic rand_payload(int unsigned n);
    pay_q.delete();
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        pay_q.push_back($urandom_range(0, 1) ? sb.flag_val : sb.esc_val);
      end else begin
        pay_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Most frames are well formed with random content. The rest carry a bad
  // CRC, are cut short, have trailing bytes, claim a wrong length, end in a
  // dangling escape, or are plain line noise with frequent restarts.
  task automatic random_frame();
    int unsigned shape;
    int unsigned plen;
    int unsigned idx;
    bit [15:0]   lenf;
    if ($urandom_range(0, 7) == 0) steady = ~steady;
    shape = $urandom_range(0, 15);
    plen  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 12);
    rand_payload(plen);
    lenf = 16'(plen);
    if (shape == 13) begin
      lenf = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                      : plen + $urandom_range(1, 4));
    end
    build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), lenf);
    case (shape)
      10: begin
        idx = frame_q.size() - 1 - $urandom_range(0, 1);
        frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      11: repeat ($urandom_range(1, frame_q.size())) void'(frame_q.pop_back());
      12: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    if (shape == 15) begin
      repeat ($urandom_range(0, 12)) begin
        send_raw(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end else begin
      send_stuffed(1'b1);
      if (shape == 14) send_byte(sb.esc_val, 1'b1);
    end
    send_byte(sb.flag_val, 1'b1);
  endtask

  task automatic write_cfg(cfg_idx_t idx, bit [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Waits until every expected item has arrived, then lets bytes which cause no
  // result also leave the pipeline.
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    bit [7:0]    same;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_END_FLAG;
    cfg_wdata = '0;
    steady    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset settings. Bytes before the first flag are
    // ignored; the second is sent in noisy mode and may carry a restart.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(sb.flag_val, 1'b0);
    // Two flags back to back form an empty frame, which is too short.
    send_byte(sb.flag_val, 1'b0);
    // A good frame whose single payload byte equals the flag and needs stuffing.
    pay_q.delete();
    pay_q.push_back(sb.flag_val);
    build_frame(8'h01, 8'h02, 16'd1);
    send_stuffed(1'b0);
    send_byte(sb.flag_val, 1'b0);
    // An escape directly before a flag: the flag still closes the frame.
    send_byte(sb.esc_val, 1'b0);
    send_byte(sb.flag_val, 1'b0);
    // A restart on the same item as a flag reopens a frame at once, no status.
    send_byte(8'h11, 1'b0);
    send_byte(sb.flag_val, 1'b1);
    // Stuffing makes the raw frame long enough while the second CRC byte is
    // missing, so the CRC is incomplete.
    pay_q.delete();
    pay_q.push_back(sb.flag_val);
    build_frame(8'hFF, 8'h00, 16'd1);
    void'(frame_q.pop_back());
    send_stuffed(1'b0);
    send_byte(sb.flag_val, 1'b0);

    while (item_count < PHASE_ITEMS) random_frame();

    // Further register settings, each written while the block is idle. They
    // cover the extremes of every register, a flag equal to the escape value
    // and a zero mask, under which stuffing cannot protect a flag byte.
    for (int ph = 1; ph <= 5; ph++) begin
      drain();
      case (ph)
        1: begin
          write_cfg(CFG_END_FLAG, 16'h0000);
          write_cfg(CFG_ESCAPE, 16'h00FF);
          write_cfg(CFG_XOR_MASK, 16'h00FF);
          write_cfg(CFG_MAX_PAYLOAD, 16'h0000);
        end
        2: begin
          write_cfg(CFG_END_FLAG, 16'h00FF);
          write_cfg(CFG_ESCAPE, 16'h0000);
          write_cfg(CFG_XOR_MASK, 16'h0000);
          write_cfg(CFG_MAX_PAYLOAD, 16'hFFFF);
        end
        3: begin
          same = 8'($urandom_range(0, 255));
          write_cfg(CFG_END_FLAG, {8'h00, same});
          write_cfg(CFG_ESCAPE, {8'h00, same});
          write_cfg(CFG_XOR_MASK, 16'($urandom_range(1, 255)));
          write_cfg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 16)));
        end
        4: begin
          write_cfg(CFG_END_FLAG, 16'($urandom_range(0, 255)));
          write_cfg(CFG_ESCAPE, 16'($urandom_range(0, 255)));
          write_cfg(CFG_XOR_MASK, 16'($urandom_range(1, 255)));
          write_cfg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 32)));
        end
        default: begin
          write_cfg(CFG_END_FLAG, {8'h00, RST_END_FLAG});
          write_cfg(CFG_ESCAPE, {8'h00, RST_ESCAPE});
          write_cfg(CFG_XOR_MASK, {8'h00, RST_XOR_MASK});
          write_cfg(CFG_MAX_PAYLOAD, RST_MAX_PAYLOAD);
        end
      endcase
      phase_end = item_count + PHASE_ITEMS;
      while (item_count < phase_end) random_frame();
    end

    drain();
    $display("Sent %0d raw bytes under six register settings.", item_count);
    $display("Compared %0d payload items and %0d end-of-frame status items.",
             sb.n_payload, sb.n_status);
    if (sb.errors == 0) begin
      $display("byte_stuffed_frame_decoder_crc16_tb: PASS");
    end else begin
      $display("byte_stuffed_frame_decoder_crc16_tb: FAIL");
    end
    $finish;
  end

endmodule
